FILE: design/sapi_pkg.sv
// Shared types and constants for the segment / axis plane intersect block.
package sapi_pkg;

    localparam int COORD_W = 32;
    localparam int EXT_W   = 33;

    // Axis codes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Configuration register byte addresses.
    localparam logic [1:0] ADDR_MIN_SPAN = 2'd0;

    localparam logic [15:0] MIN_SPAN_RESET = 16'd21;

    // Input transaction.
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic signed [31:0] plane_value;
    } t_seg_in;

    // Result transaction.
    typedef struct packed {
        logic               hit;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_seg_out;

endpackage

FILE: design/sapi_if.sv
// Valid/ready stream interfaces for the input and result channels.
interface sapi_in_if
    import sapi_pkg::*;
();
    logic    valid;
    logic    ready;
    t_seg_in data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sapi_out_if
    import sapi_pkg::*;
();
    logic     valid;
    logic     ready;
    t_seg_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/sapi_div_cell.sv
// One restoring-division cell: one quotient bit per cell, carries the whole item.
module sapi_div_cell
    import sapi_pkg::*;
#(
    parameter int QW = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic                  i_hit,
    input  logic [EXT_W-1:0]      i_rem,
    input  logic                  i_bit,
    input  logic [EXT_W-1:0]      i_den,
    input  logic [QW-1:0]         i_quo,
    input  logic signed [EXT_W-1:0] i_dx,
    input  logic signed [EXT_W-1:0] i_dy,
    input  logic signed [EXT_W-1:0] i_dz,
    input  logic signed [31:0]    i_sx,
    input  logic signed [31:0]    i_sy,
    input  logic signed [31:0]    i_sz,
    output logic                  o_valid,
    output logic                  o_hit,
    output logic [EXT_W-1:0]      o_rem,
    output logic [EXT_W-1:0]      o_den,
    output logic [QW-1:0]         o_quo,
    output logic signed [EXT_W-1:0] o_dx,
    output logic signed [EXT_W-1:0] o_dy,
    output logic signed [EXT_W-1:0] o_dz,
    output logic signed [31:0]    o_sx,
    output logic signed [31:0]    o_sy,
    output logic signed [31:0]    o_sz
);
    logic [EXT_W:0] w_sh;
    logic [EXT_W:0] w_diff;
    logic           w_ge;

    // Shift next dividend bit into remainder, trial subtract.
    assign w_sh   = {i_rem, i_bit};
    assign w_diff = w_sh - {1'b0, i_den};
    assign w_ge   = ~w_diff[EXT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit <= i_hit;
            o_rem <= w_ge ? w_diff[EXT_W-1:0] : w_sh[EXT_W-1:0];
            o_den <= i_den;
            o_quo <= {i_quo[QW-2:0], w_ge};
            o_dx  <= i_dx;
            o_dy  <= i_dy;
            o_dz  <= i_dz;
            o_sx  <= i_sx;
            o_sy  <= i_sy;
            o_sz  <= i_sz;
        end
    end
endmodule

FILE: design/segment_axis_plane_intersect.sv
// Top level: segment against axis-aligned plane intersection pipeline.
// Usage:
//   Input channel (sapi_in_if sink) takes a segment, axis code and plane value.
//   Result channel (sapi_out_if source) gives hit and the intersection point,
//   point fields are zero when there is no hit. One result per input.
//   APB port holds min_span at address 0 (reset 21); write only while idle.
// Pipeline: front stage, FRAC_BITS + 1 divider cells, one multiply stage,
//   output register with add.
// Throughput: one transaction per cycle while the pipe is not stalled; the row
//   of divider cells, one quotient bit per cell, sets the depth.
// Stall: the whole pipe advances together; when the receiver holds ready low
//   with a result waiting in the output register, the whole pipe freezes and
//   input ready drops, bubbles included, until the result is taken.
// Reset: synchronous, active low; clears all valid bits and min_span to 21.
module segment_axis_plane_intersect
    import sapi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sapi_in_if.sink     in_ch,
    sapi_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int QW    = FRAC_BITS + 1;
    localparam int NC    = QW;
    localparam int PW    = EXT_W + QW;

    logic [15:0] r_min_span;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MIN_SPAN) ? {16'd0, r_min_span} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_span <= MIN_SPAN_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_MIN_SPAN) begin
            r_min_span <= pwdata[15:0];
        end
    end

    // Global advance: pipe moves unless the output register holds a stalled result.
    logic w_en;
    logic r_out_valid;
    assign w_en = !r_out_valid || out_ch.ready;
    assign in_ch.ready = w_en;

    // Front stage: extents, offset, range test.
    logic signed [EXT_W-1:0] w_dx, w_dy, w_dz, w_da, w_n;
    logic [EXT_W-1:0]        w_ad, w_an;
    logic                    w_hit;
    t_seg_in                 w_i;
    assign w_i  = in_ch.data;
    assign w_dx = EXT_W'(w_i.end_x) - EXT_W'(w_i.start_x);
    assign w_dy = EXT_W'(w_i.end_y) - EXT_W'(w_i.start_y);
    assign w_dz = EXT_W'(w_i.end_z) - EXT_W'(w_i.start_z);

    always_comb begin
        case (w_i.cmd)
            AXIS_X: begin
                w_da = w_dx;
                w_n  = EXT_W'(w_i.plane_value) - EXT_W'(w_i.start_x);
            end
            AXIS_Y: begin
                w_da = w_dy;
                w_n  = EXT_W'(w_i.plane_value) - EXT_W'(w_i.start_y);
            end
            AXIS_Z: begin
                w_da = w_dz;
                w_n  = EXT_W'(w_i.plane_value) - EXT_W'(w_i.start_z);
            end
            default: begin
                w_da = '0;
                w_n  = '0;
            end
        endcase
    end
    assign w_ad  = w_da[EXT_W-1] ? EXT_W'(-w_da) : EXT_W'(w_da);
    assign w_an  = w_n[EXT_W-1] ? EXT_W'(-w_n) : EXT_W'(w_n);
    assign w_hit = (w_i.cmd != 2'd3) && (w_ad != '0)
                && (w_ad >= EXT_W'(r_min_span))
                && ((w_n == '0) || (w_n[EXT_W-1] == w_da[EXT_W-1]))
                && (w_an <= w_ad);

    // Row of divider cells; stage 0 is the front register.
    logic                    c_valid [NC+1];
    logic                    c_hit   [NC+1];
    logic [EXT_W-1:0]        c_rem   [NC+1];
    logic [EXT_W-1:0]        c_den   [NC+1];
    logic [QW-1:0]           c_quo   [NC+1];
    logic signed [EXT_W-1:0] c_dx    [NC+1];
    logic signed [EXT_W-1:0] c_dy    [NC+1];
    logic signed [EXT_W-1:0] c_dz    [NC+1];
    logic signed [31:0]      c_sx    [NC+1];
    logic signed [31:0]      c_sy    [NC+1];
    logic signed [31:0]      c_sz    [NC+1];
    logic                    r_an_lsb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_valid[0] <= 1'b0;
        end else if (w_en) begin
            c_valid[0] <= in_ch.valid;
        end
    end
    // Dividend is an followed by FRAC_BITS zeros. The first cell starts from
    // an>>1 and shifts in an's LSB, so its trial compare is an against ad.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            c_hit[0] <= w_hit;
            c_rem[0] <= w_hit ? {1'b0, w_an[EXT_W-1:1]} : '0;
            r_an_lsb <= w_hit & w_an[0];
            c_den[0] <= w_hit ? w_ad : EXT_W'(1);
            c_quo[0] <= '0;
            c_dx[0]  <= w_dx;
            c_dy[0]  <= w_dy;
            c_dz[0]  <= w_dz;
            c_sx[0]  <= w_i.start_x;
            c_sy[0]  <= w_i.start_y;
            c_sz[0]  <= w_i.start_z;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NC; g++) begin : g_cell
            logic w_bit;
            if (g == 0) begin : g_first
                assign w_bit = r_an_lsb;
            end else begin : g_rest
                assign w_bit = 1'b0;
            end
            sapi_div_cell #(.QW(QW)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (c_valid[g]),
                .i_hit   (c_hit[g]),
                .i_rem   (c_rem[g]),
                .i_bit   (w_bit),
                .i_den   (c_den[g]),
                .i_quo   (c_quo[g]),
                .i_dx    (c_dx[g]),
                .i_dy    (c_dy[g]),
                .i_dz    (c_dz[g]),
                .i_sx    (c_sx[g]),
                .i_sy    (c_sy[g]),
                .i_sz    (c_sz[g]),
                .o_valid (c_valid[g+1]),
                .o_hit   (c_hit[g+1]),
                .o_rem   (c_rem[g+1]),
                .o_den   (c_den[g+1]),
                .o_quo   (c_quo[g+1]),
                .o_dx    (c_dx[g+1]),
                .o_dy    (c_dy[g+1]),
                .o_dz    (c_dz[g+1]),
                .o_sx    (c_sx[g+1]),
                .o_sy    (c_sy[g+1]),
                .o_sz    (c_sz[g+1])
            );
        end
    endgenerate

    // Multiply stage: |delta| * t on all axes.
    logic               r_m_valid, r_m_hit;
    logic [PW-1:0]      r_px, r_py, r_pz;
    logic               r_nx, r_ny, r_nz;
    logic signed [31:0] r_msx, r_msy, r_msz;
    logic [EXT_W-1:0]   w_mx, w_my, w_mz;
    logic [QW-1:0]      w_t;
    // High quotient bit, from cell 0, is the t integer bit (an == ad gives t = 1).
    assign w_t  = c_quo[NC] | {1'b0, {FRAC_BITS{1'b0}}} ;
    assign w_mx = c_dx[NC][EXT_W-1] ? EXT_W'(-c_dx[NC]) : EXT_W'(c_dx[NC]);
    assign w_my = c_dy[NC][EXT_W-1] ? EXT_W'(-c_dy[NC]) : EXT_W'(c_dy[NC]);
    assign w_mz = c_dz[NC][EXT_W-1] ? EXT_W'(-c_dz[NC]) : EXT_W'(c_dz[NC]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= c_valid[NC];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_hit <= c_hit[NC];
            r_px    <= PW'(w_mx) * PW'(w_t);
            r_py    <= PW'(w_my) * PW'(w_t);
            r_pz    <= PW'(w_mz) * PW'(w_t);
            r_nx    <= c_dx[NC][EXT_W-1];
            r_ny    <= c_dy[NC][EXT_W-1];
            r_nz    <= c_dz[NC][EXT_W-1];
            r_msx   <= c_sx[NC];
            r_msy   <= c_sy[NC];
            r_msz   <= c_sz[NC];
        end
    end

    // Add stage into output register.
    logic [EXT_W-1:0] w_qx, w_qy, w_qz;
    t_seg_out         r_out;
    assign w_qx = r_px[FRAC_BITS +: EXT_W];
    assign w_qy = r_py[FRAC_BITS +: EXT_W];
    assign w_qz = r_pz[FRAC_BITS +: EXT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_m_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.hit     <= r_m_hit;
            r_out.point_x <= r_m_hit ? 32'(r_msx + (r_nx ? 32'(-w_qx) : 32'(w_qx))) : '0;
            r_out.point_y <= r_m_hit ? 32'(r_msy + (r_ny ? 32'(-w_qy) : 32'(w_qy))) : '0;
            r_out.point_z <= r_m_hit ? 32'(r_msz + (r_nz ? 32'(-w_qz) : 32'(w_qz))) : '0;
        end
    end

    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = r_out;
endmodule
